>>> rtl/rgbf_pkg.sv
package rgbf_pkg;

    localparam int ChanW = 8;

    typedef logic [1:0]       req_kind_t;
    typedef logic [ChanW-1:0] duty_t;

    localparam req_kind_t REQ_TICK       = 2'd0;
    localparam req_kind_t REQ_BRIGHT     = 2'd1;
    localparam req_kind_t REQ_FADE       = 2'd2;
    localparam req_kind_t REQ_FADE_EVENT = 2'd3;

    typedef struct packed {
        req_kind_t req_type;
        duty_t     red_value;
        duty_t     green_value;
        duty_t     blue_value;
        duty_t     bright_value;
    } req_t;

    typedef struct packed {
        duty_t red;
        duty_t green;
        duty_t blue;
        duty_t bright;
    } color_t;

    typedef struct packed {
        color_t cur;
        color_t goal;
        logic   fade_active;
        logic   notify_on_done;
    } fade_state_t;

    typedef struct packed {
        duty_t red_drive;
        duty_t green_drive;
        duty_t blue_drive;
        duty_t bright_drive;
        logic  fading;
        logic  timeout_event;
    } rsp_t;

endpackage

>>> rtl/rgbf_req_if.sv
interface rgbf_req_if
    import rgbf_pkg::*;
;
    logic  valid;
    logic  ready;
    req_kind_t req_type;
    duty_t red_value;
    duty_t green_value;
    duty_t blue_value;
    duty_t bright_value;

    modport source (
        output valid, req_type, red_value, green_value, blue_value, bright_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, red_value, green_value, blue_value, bright_value,
        output ready
    );
endinterface

>>> rtl/rgbf_rsp_if.sv
interface rgbf_rsp_if
    import rgbf_pkg::*;
;
    logic  valid;
    logic  ready;
    duty_t red_drive;
    duty_t green_drive;
    duty_t blue_drive;
    duty_t bright_drive;
    logic  fading;
    logic  timeout_event;

    modport source (
        output valid, red_drive, green_drive, blue_drive, bright_drive, fading,
               timeout_event,
        input  ready
    );
    modport sink (
        input  valid, red_drive, green_drive, blue_drive, bright_drive, fading,
               timeout_event,
        output ready
    );
endinterface

>>> rtl/rgbf_step.sv
module rgbf_step
    import rgbf_pkg::*;
(
    input  req_t        req,
    input  fade_state_t state,
    output fade_state_t state_next,
    output logic        timeout_event
);

    function automatic duty_t step_toward(input duty_t now, input duty_t goal);
        duty_t res;
        begin
            if (now > goal)
            begin
                res = now - duty_t'(1);
            end
            else if (now < goal)
            begin
                res = now + duty_t'(1);
            end
            else
            begin
                res = now;
            end
            return res;
        end
    endfunction

    fade_state_t cmd_state;
    fade_state_t stepped;
    logic        reached;

    // apply the command first
    always_comb
    begin
        cmd_state = state;
        unique case (req.req_type) inside
            REQ_TICK:
            begin
                cmd_state = state;
            end
            REQ_BRIGHT:
            begin
                cmd_state.cur.bright = req.bright_value;
            end
            REQ_FADE, REQ_FADE_EVENT:
            begin
                cmd_state.fade_active    = 1'b1;
                cmd_state.goal.red       = req.red_value;
                cmd_state.goal.green     = req.green_value;
                cmd_state.goal.blue      = req.blue_value;
                cmd_state.goal.bright    = req.bright_value;
                cmd_state.notify_on_done = (req.req_type == REQ_FADE_EVENT);
            end
            default:
            begin
                cmd_state = state;
            end
        endcase
    end

    // then advance one step toward the goals and test completion
    always_comb
    begin
        stepped            = cmd_state;
        stepped.cur.red    = step_toward(cmd_state.cur.red,    cmd_state.goal.red);
        stepped.cur.green  = step_toward(cmd_state.cur.green,  cmd_state.goal.green);
        stepped.cur.blue   = step_toward(cmd_state.cur.blue,   cmd_state.goal.blue);
        stepped.cur.bright = step_toward(cmd_state.cur.bright, cmd_state.goal.bright);
        reached = (stepped.cur == stepped.goal);

        state_next    = cmd_state;
        timeout_event = 1'b0;
        if (cmd_state.fade_active)
        begin
            state_next = stepped;
            if (reached)
            begin
                state_next.fade_active = 1'b0;
                timeout_event          = cmd_state.notify_on_done;
            end
        end
    end

endmodule

>>> rtl/rgb_led_fade_ramp_unit.sv
// RGB LED fade engine with a separate brightness channel.
// req carries one loop tick per transfer, optionally with a command:
// tick only, brightness set, color fade, or color fade with a timeout
// event. rsp returns one result per tick: the four PWM duties after the
// tick, the fading flag and the one-tick timeout_event.
// Pipeline: one input register and one result register. The per-channel
// +1/-1/hold step and the four equality compares sit between the input
// and result registers. Throughput: one tick per cycle unless rsp stalls.
// Reset clears all duties, goals and the fade flags to zero and empties
// both pipeline registers.
// When rsp stalls, the result register holds, the input register holds
// its item, and req.ready drops only once both are full, so no tick is
// lost or repeated.
module rgb_led_fade_ramp_unit
    import rgbf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rgbf_req_if.sink   req,
    rgbf_rsp_if.source rsp
);

    logic        in_valid_reg;
    req_t        in_req_reg;
    logic        out_valid_reg;
    rsp_t        out_reg;
    fade_state_t state_reg;
    fade_state_t state_next;
    logic        timeout_event;
    logic        advance;

    rgbf_step u_step (
        .req           (in_req_reg),
        .state         (state_reg),
        .state_next    (state_next),
        .timeout_event (timeout_event)
    );

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_req_reg.req_type     <= req.req_type;
            in_req_reg.red_value    <= req.red_value;
            in_req_reg.green_value  <= req.green_value;
            in_req_reg.blue_value   <= req.blue_value;
            in_req_reg.bright_value <= req.bright_value;
        end
        if (advance && in_valid_reg)
        begin
            out_reg.red_drive     <= state_next.cur.red;
            out_reg.green_drive   <= state_next.cur.green;
            out_reg.blue_drive    <= state_next.cur.blue;
            out_reg.bright_drive  <= state_next.cur.bright;
            out_reg.fading        <= state_next.fade_active;
            out_reg.timeout_event <= timeout_event;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.red_drive     = out_reg.red_drive;
    assign rsp.green_drive   = out_reg.green_drive;
    assign rsp.blue_drive    = out_reg.blue_drive;
    assign rsp.bright_drive  = out_reg.bright_drive;
    assign rsp.fading        = out_reg.fading;
    assign rsp.timeout_event = out_reg.timeout_event;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import rgbf_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int RandomItems = 540;
    localparam int DirRows     = 16;
    localparam int ReportMax   = 10;
    localparam int DrainCycles = 8;

    typedef struct packed {
        req_t item;
        logic typed;
        rsp_t want;
    } tick_row_t;

    logic clk;
    logic rst_n;

    rgbf_req_if req_bus ();
    rgbf_rsp_if rsp_bus ();

    rgb_led_fade_ramp_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // predicted lamp state
    color_t lamp_now;
    color_t lamp_goal;
    logic   fade_on;
    logic   notify_on;

    rsp_t   drive_q[$];
    int     fail_cnt = 0;
    int     cyc = 0;

    // Directed ticks; typed rows carry the duty values that follow directly from reset.
    tick_row_t tick_tbl [DirRows] = '{
        '{'{REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
        '{'{REQ_TICK, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
        '{'{REQ_BRIGHT, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'hff, 1'b0, 1'b0}},
        '{'{REQ_BRIGHT, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
        // targets already reached: start and finish in one tick
        '{'{REQ_FADE_EVENT, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
        '{'{REQ_FADE, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
        '{'{REQ_FADE, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
          '{8'h01, 8'h01, 8'h01, 8'h01, 1'b1, 1'b0}},
        '{'{REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        // brightness set mid-fade, then stepped in the same tick
        '{'{REQ_BRIGHT, 8'h00, 8'h00, 8'h00, 8'd200}, 1'b0, '0},
        // retarget mid-fade
        '{'{REQ_FADE_EVENT, 8'd3, 8'd0, 8'd2, 8'd255}, 1'b0, '0},
        '{'{REQ_FADE_EVENT, 8'd5, 8'd1, 8'd2, 8'd203}, 1'b0, '0},
        // completing tick is not a colour command; stored kind raises the event
        '{'{REQ_BRIGHT, 8'h55, 8'haa, 8'h55, 8'd203}, 1'b0, '0},
        '{'{REQ_FADE, 8'd5, 8'd1, 8'd2, 8'd205}, 1'b0, '0},
        '{'{REQ_TICK, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
        '{'{REQ_FADE_EVENT, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{REQ_TICK, 8'haa, 8'h55, 8'haa, 8'h55}, 1'b0, '0}
    };

    function automatic duty_t nudge(duty_t now, duty_t goal);
        if (now > goal)
            return now - 1'b1;
        if (now < goal)
            return now + 1'b1;
        return now;
    endfunction

    function automatic rsp_t advance_lamp(req_t it);
        rsp_t r;
        r.timeout_event = 1'b0;
        if (it.req_type == REQ_BRIGHT)
        begin
            lamp_now.bright = it.bright_value;
        end
        else if (it.req_type == REQ_FADE || it.req_type == REQ_FADE_EVENT)
        begin
            fade_on   = 1'b1;
            lamp_goal = '{it.red_value, it.green_value, it.blue_value, it.bright_value};
            notify_on = (it.req_type == REQ_FADE_EVENT);
        end
        if (fade_on)
        begin
            lamp_now.red    = nudge(lamp_now.red, lamp_goal.red);
            lamp_now.green  = nudge(lamp_now.green, lamp_goal.green);
            lamp_now.blue   = nudge(lamp_now.blue, lamp_goal.blue);
            lamp_now.bright = nudge(lamp_now.bright, lamp_goal.bright);
            if (lamp_now == lamp_goal)
            begin
                r.timeout_event = notify_on;
                fade_on         = 1'b0;
            end
        end
        r.red_drive    = lamp_now.red;
        r.green_drive  = lamp_now.green;
        r.blue_drive   = lamp_now.blue;
        r.bright_drive = lamp_now.bright;
        r.fading       = fade_on;
        return r;
    endfunction

    function automatic duty_t near_duty(duty_t base);
        int v;
        v = int'(base) + $urandom_range(12) - 6;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return duty_t'(v);
    endfunction

    // Mostly ticks and short fades so that fades finish often; some far targets.
    function automatic req_t pick_tick();
        req_t it;
        int   roll;
        roll = $urandom_range(99);
        it.red_value    = duty_t'($urandom_range(255));
        it.green_value  = duty_t'($urandom_range(255));
        it.blue_value   = duty_t'($urandom_range(255));
        it.bright_value = duty_t'($urandom_range(255));
        if (roll < 50)
            it.req_type = REQ_TICK;
        else if (roll < 60)
            it.req_type = REQ_BRIGHT;
        else if (roll < 78)
            it.req_type = REQ_FADE;
        else
            it.req_type = REQ_FADE_EVENT;
        if (it.req_type[1] && $urandom_range(99) < 75)
        begin
            it.red_value    = near_duty(lamp_now.red);
            it.green_value  = near_duty(lamp_now.green);
            it.blue_value   = near_duty(lamp_now.blue);
            it.bright_value = near_duty(lamp_now.bright);
        end
        return it;
    endfunction

    // Offer one tick, with optional random gaps ahead of it, and hold until transfer.
    task automatic offer_tick(input req_t it, input bit typed, input rsp_t want,
                              input bit gaps_ok);
        rsp_t predicted;
        @(negedge clk);
        while (gaps_ok && $urandom_range(99) < 24) begin
            req_bus.valid = 1'b0;
            @(negedge clk);
        end
        req_bus.valid        = 1'b1;
        req_bus.req_type     = it.req_type;
        req_bus.red_value    = it.red_value;
        req_bus.green_value  = it.green_value;
        req_bus.blue_value   = it.blue_value;
        req_bus.bright_value = it.bright_value;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        predicted = advance_lamp(it);
        drive_q.push_back(typed ? want : predicted);
    endtask

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc == CycleLimit)
        begin
            $display("FAIL rgb_led_fade_ramp_unit");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off, one stretch with no stalls
    initial
    begin : sink_side
        int rx_cycle;
        rx_cycle      = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle >= 400 && rx_cycle < 480)
                rsp_bus.ready = 1'b0;
            else if (rx_cycle >= 600 && rx_cycle < 760)
                rsp_bus.ready = 1'b1;
            else
                rsp_bus.ready = ($urandom_range(99) >= 24);
        end
    end

    always @(posedge clk)
    begin : drive_check
        rsp_t got;
        rsp_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got = '{rsp_bus.red_drive, rsp_bus.green_drive, rsp_bus.blue_drive,
                    rsp_bus.bright_drive, rsp_bus.fading, rsp_bus.timeout_event};
            if (drive_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= ReportMax)
                    $display("unexpected transfer r=%0d g=%0d b=%0d l=%0d fading=%b ev=%b",
                             got.red_drive, got.green_drive, got.blue_drive,
                             got.bright_drive, got.fading, got.timeout_event);
            end
            else
            begin
                want = drive_q.pop_front();
                if (got.red_drive !== want.red_drive || got.green_drive !== want.green_drive ||
                    got.blue_drive !== want.blue_drive ||
                    got.bright_drive !== want.bright_drive ||
                    got.fading !== want.fading || got.timeout_event !== want.timeout_event)
                begin
                    fail_cnt++;
                    if (fail_cnt <= ReportMax)
                    begin
                        $write("mismatch exp r=%0d g=%0d b=%0d l=%0d f=%b e=%b",
                               want.red_drive, want.green_drive, want.blue_drive,
                               want.bright_drive, want.fading, want.timeout_event);
                        $display(" | got r=%0d g=%0d b=%0d l=%0d f=%b e=%b",
                                 got.red_drive, got.green_drive, got.blue_drive,
                                 got.bright_drive, got.fading, got.timeout_event);
                    end
                end
            end
        end
    end

    initial
    begin : source_side
        req_t it;
        bit   gaps_ok;
        lamp_now             = '0;
        lamp_goal            = '0;
        fade_on              = 1'b0;
        notify_on            = 1'b0;
        rst_n                = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.req_type     = REQ_TICK;
        req_bus.red_value    = '0;
        req_bus.green_value  = '0;
        req_bus.blue_value   = '0;
        req_bus.bright_value = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        foreach (tick_tbl[i])
            offer_tick(tick_tbl[i].item, tick_tbl[i].typed, tick_tbl[i].want, 1'b1);

        for (int n = 0; n < RandomItems; n++)
        begin
            gaps_ok = (n < 200 || n >= 330);
            it = pick_tick();
            offer_tick(it, 1'b0, '0, gaps_ok);
        end
        @(negedge clk);
        req_bus.valid = 1'b0;

        while (drive_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (fail_cnt == 0)
            $display("PASS rgb_led_fade_ramp_unit");
        else
            $display("FAIL rgb_led_fade_ramp_unit");
        $finish;
    end

endmodule
